// ----- rtl/jfhp_pkg.sv -----
// ----------------------------------------------------------------------------
// jfhp_pkg
// Shared constants and types for the frame header parser: field positions,
// normalization masks and the packed result word.
// ----------------------------------------------------------------------------
package jfhp_pkg;

  // number of components whose sampling factors are stored
  localparam int KEPT_COMPONENTS = 4;
  localparam int KEPT_IDX_W      = (KEPT_COMPONENTS > 1) ? $clog2(KEPT_COMPONENTS) : 1;

  // byte positions of the fixed part of the header
  localparam logic [2:0] POS_LEN_HI    = 3'd0;
  localparam logic [2:0] POS_LEN_LO    = 3'd1;
  localparam logic [2:0] POS_PRECISION = 3'd2;
  localparam logic [2:0] POS_HEIGHT_HI = 3'd3;
  localparam logic [2:0] POS_HEIGHT_LO = 3'd4;
  localparam logic [2:0] POS_WIDTH_HI  = 3'd5;
  localparam logic [2:0] POS_WIDTH_LO  = 3'd6;
  localparam logic [2:0] POS_COUNT     = 3'd7;

  // byte slots inside one component record
  localparam logic [1:0] CB_IDENT  = 2'd0;
  localparam logic [1:0] CB_FACTOR = 2'd1;
  localparam logic [1:0] CB_TABLE  = 2'd2;

  // format code normalization
  localparam logic [31:0] H_ODD_MASK  = 32'hD0D0_D0D0;
  localparam logic [31:0] H_NIB_MASK  = 32'hF0F0_F0F0;
  localparam logic [31:0] V_ODD_MASK  = 32'h0D0D_0D0D;
  localparam logic [31:0] V_NIB_MASK  = 32'h0F0F_0F0F;
  localparam logic [31:0] CODE_444    = 32'h1111_1100;
  localparam logic [3:0]  NIBBLE_MASK = 4'b1111;

  // one result word
  typedef struct packed {
    logic        accepted;
    logic [31:0] format_code;
    logic [3:0]  max_vertical_factor;
    logic [3:0]  max_horizontal_factor;
    logic [7:0]  component_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  sample_precision;
    logic [15:0] segment_length;
  } result_t;

endpackage

// ----- rtl/jpeg_frame_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// jpeg_frame_header_parser_unit
// Parses the bytes of a baseline frame header and emits one summary word.
// ----------------------------------------------------------------------------
// One header byte is taken per cycle while s_axis_tready is high, with
// first_byte on tuser marking the high length byte of a new header; it
// drops any header in progress. The result word for the last component byte
// (or the count byte when the count is zero) is registered into the result
// register, or into the skid register while an earlier result waits. The
// rate is set by the byte-wide parse register update; a two-entry output
// (result register plus skid register) keeps the input open while a result
// waits, so the slave side stalls only when both entries are full. Bytes that
// arrive after a header is complete are dropped until the next first_byte.
module jpeg_frame_header_parser_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // data_byte[7:0]
  input  logic          s_axis_tuser,   // first_byte[0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // segment_length[15:0], sample_precision[23:16],
                                        // image_height[39:24], image_width[55:40],
                                        // component_count[63:56],
                                        // max_horizontal_factor[67:64],
                                        // max_vertical_factor[71:68],
                                        // format_code[103:72]
  output logic          m_axis_tuser    // accepted[0]
);
  import jfhp_pkg::*;

  // parse state
  logic [2:0]  byte_position;
  logic        parse_active;
  logic        in_components;
  logic [15:0] length_reg;
  logic [7:0]  precision_reg;
  logic [15:0] height_reg;
  logic [15:0] width_reg;
  logic [7:0]  count_reg;
  logic [7:0]  component_index;
  logic [1:0]  component_byte;
  logic [7:0]  factor_store [KEPT_COMPONENTS];
  logic [3:0]  max_h_reg;
  logic [3:0]  max_v_reg;

  // output stage
  result_t     out_word;
  result_t     skid_word;
  logic        out_valid;
  logic        skid_valid;

  logic        accept;
  logic        pop;
  logic        emit;
  logic        last_component;
  logic [3:0]  byte_h;
  logic [3:0]  byte_v;
  logic [31:0] raw_code;
  logic [31:0] h_code;
  logic [31:0] v_code;
  result_t     result_next;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;

  assign byte_h = s_axis_tdata[7:4];
  assign byte_v = s_axis_tdata[3:0];

  // end of header detection
  always_comb begin
    last_component = ({1'b0, component_index} + 9'd1) >= {1'b0, count_reg};
    emit = 1'b0;
    if (!s_axis_tuser && parse_active) begin
      if (!in_components) begin
        emit = (byte_position == POS_COUNT) && (s_axis_tdata == 8'd0);
      end else begin
        emit = (component_byte >= CB_TABLE) && last_component;
      end
    end
  end

  // factor code and halving normalization
  always_comb begin
    raw_code = {factor_store[0], factor_store[1], factor_store[2], factor_store[3]};
    if ((raw_code & H_ODD_MASK) == 32'd0) begin
      h_code = raw_code - ((raw_code & H_NIB_MASK) >> 1);
    end else begin
      h_code = raw_code;
    end
    if ((h_code & V_ODD_MASK) == 32'd0) begin
      v_code = h_code - ((h_code & V_NIB_MASK) >> 1);
    end else begin
      v_code = h_code;
    end
  end

  // result word for the byte that ends the header
  always_comb begin
    result_next.segment_length        = length_reg;
    result_next.sample_precision      = precision_reg;
    result_next.image_height          = height_reg;
    result_next.image_width           = width_reg;
    result_next.component_count       = in_components ? count_reg : s_axis_tdata;
    result_next.max_horizontal_factor = max_h_reg & NIBBLE_MASK;
    result_next.max_vertical_factor   = max_v_reg & NIBBLE_MASK;
    result_next.format_code           = v_code;
    result_next.accepted              = (v_code == CODE_444);
  end

  // header byte parsing
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_LEN_HI;
      parse_active    <= 1'b0;
      in_components   <= 1'b0;
      component_index <= 8'd0;
      component_byte  <= CB_IDENT;
    end else if (accept) begin
      if (s_axis_tuser) begin
        parse_active    <= 1'b1;
        in_components   <= 1'b0;
        byte_position   <= POS_LEN_LO;
        length_reg      <= {s_axis_tdata, 8'd0};
        precision_reg   <= 8'd0;
        height_reg      <= 16'd0;
        width_reg       <= 16'd0;
        count_reg       <= 8'd0;
        component_index <= 8'd0;
        component_byte  <= CB_IDENT;
        max_h_reg       <= 4'd1;
        max_v_reg       <= 4'd1;
        for (int k = 0; k < KEPT_COMPONENTS; k++) begin
          factor_store[k] <= 8'd0;
        end
      end else if (parse_active) begin
        if (!in_components) begin
          case (byte_position)
            POS_LEN_HI:    length_reg <= {s_axis_tdata, 8'd0};
            POS_LEN_LO:    length_reg <= {length_reg[15:8], s_axis_tdata};
            POS_PRECISION: precision_reg <= s_axis_tdata;
            POS_HEIGHT_HI: height_reg <= {s_axis_tdata, 8'd0};
            POS_HEIGHT_LO: height_reg <= {height_reg[15:8], s_axis_tdata};
            POS_WIDTH_HI:  width_reg <= {s_axis_tdata, 8'd0};
            POS_WIDTH_LO:  width_reg <= {width_reg[15:8], s_axis_tdata};
            default: begin
              count_reg       <= s_axis_tdata;
              in_components   <= 1'b1;
              component_index <= 8'd0;
              component_byte  <= CB_IDENT;
            end
          endcase
          if (byte_position != POS_COUNT) begin
            byte_position <= byte_position + 3'd1;
          end
          if (emit) begin
            parse_active <= 1'b0;
          end
        end else begin
          // component record: identifier, factors, table selector
          if (component_byte == CB_FACTOR) begin
            if (component_index < 8'(KEPT_COMPONENTS)) begin
              factor_store[component_index[KEPT_IDX_W-1:0]] <= s_axis_tdata;
            end
            if (byte_h > max_h_reg) begin
              max_h_reg <= byte_h;
            end
            if (byte_v > max_v_reg) begin
              max_v_reg <= byte_v;
            end
          end
          if (component_byte >= CB_TABLE) begin
            component_byte <= CB_IDENT;
            if (last_component) begin
              parse_active <= 1'b0;
            end else begin
              component_index <= component_index + 8'd1;
            end
          end else begin
            component_byte <= component_byte + 2'd1;
          end
        end
      end
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (accept && emit) begin
      if (!out_valid || pop) begin
        out_word  <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_word.accepted;
  assign m_axis_tdata  = {out_word.format_code,
                          out_word.max_vertical_factor,
                          out_word.max_horizontal_factor,
                          out_word.component_count,
                          out_word.image_width,
                          out_word.image_height,
                          out_word.sample_precision,
                          out_word.segment_length};

endmodule
